// ===== hw/rtl/cbc_pkg.sv =====
// ----------------------------------------------------------------------------
// cbc_pkg
// Shared types and constants of the cartridge bank controller.
// ----------------------------------------------------------------------------
package cbc_pkg;

    localparam int ADDR_W     = 15;
    localparam int DATA_W     = 8;
    localparam int ROM_BANK_W = 9;
    localparam int RAM_BANK_W = 4;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    // Mapper kinds
    localparam logic [KIND_W-1:0] KIND_PLAIN       = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MBC1        = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MBC5        = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNSUPPORTED = 2'd3;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_MAPPER_KIND   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROM_BANK_MASK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RAM_BANK_MASK = 2'd2;

    // Reset values of the configuration
    localparam logic [KIND_W-1:0]     MAPPER_KIND_RST   = KIND_PLAIN;
    localparam logic [ROM_BANK_W-1:0] ROM_BANK_MASK_RST = 9'd1;
    localparam logic [RAM_BANK_W-1:0] RAM_BANK_MASK_RST = 4'd0;

    // Low nibble that enables external RAM
    localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

    typedef struct packed {
        logic [KIND_W-1:0]     mapper_kind;
        logic [ROM_BANK_W-1:0] rom_bank_mask;
        logic [RAM_BANK_W-1:0] ram_bank_mask;
    } cfg_t;

    typedef struct packed {
        logic                  ram_enable_flag;
        logic [4:0]            low_bank_field;
        logic [1:0]            high_bank_field;
        logic                  mode_select;
        logic [ROM_BANK_W-1:0] current_rom_bank;
        logic [RAM_BANK_W-1:0] current_ram_bank;
    } bank_state_t;

    localparam bank_state_t BANK_STATE_RST = '{
        ram_enable_flag:  1'b0,
        low_bank_field:   5'd0,
        high_bank_field:  2'd0,
        mode_select:      1'b0,
        current_rom_bank: 9'd1,
        current_ram_bank: 4'd0
    };

endpackage

// ===== hw/rtl/cartridge_bank_controller_unit.sv =====
// ----------------------------------------------------------------------------
// cartridge_bank_controller_unit
// Bank register logic of an MBC1 / MBC5 style game cartridge controller.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one CPU write to the
//   cartridge ROM area: write_addr below 0x8000 and write_data.
//   Output channel (out_valid / out_stall) returns one transfer per input
//   transfer: ROM bank, RAM bank and RAM enable after that write.
//   Configuration channel (cfg_valid / cfg_ready, always ready) writes
//   mapper_kind (0), rom_bank_mask (1) and ram_bank_mask (2); write it only
//   while no input transfer is in flight.
// Timing:
//   Two register stages: a write lands in the input register, then the bank
//   update runs and the result register loads as soon as it is free.
//   Throughput is one write per cycle while out_stall stays low.
// Reset (rst_n low, asynchronous): both stages empty, plain ROM kind, ROM
//   bank 1, RAM bank 0, RAM disabled, rom_bank_mask 1, ram_bank_mask 0.
// Stall: while out_stall holds a full result register, the input register
//   keeps its write and in_stall rises once it is full as well.
// ----------------------------------------------------------------------------
module cartridge_bank_controller_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    // write input
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [cbc_pkg::ADDR_W-1:0]     write_addr,
    input  logic [cbc_pkg::DATA_W-1:0]     write_data,
    // bank result output
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [cbc_pkg::ROM_BANK_W-1:0] rom_bank_now,
    output logic [cbc_pkg::RAM_BANK_W-1:0] ram_bank_now,
    output logic                           ram_enabled_now,
    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cbc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cbc_pkg::*;

    cfg_t                  cfg;

    // Input register stage
    logic                  in_valid_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic [DATA_W-1:0]     data_reg;

    // Bank state, updated as a write moves into the result register
    bank_state_t           state_reg;
    bank_state_t           state_next;

    // Result register stage
    logic                  out_valid_reg;
    logic [ROM_BANK_W-1:0] rom_bank_reg;
    logic [RAM_BANK_W-1:0] ram_bank_reg;
    logic                  ram_en_reg;

    logic                  out_free;
    logic                  advance;
    logic                  in_take;

    cbc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cbc_bank_logic u_bank_logic (
        .cfg        (cfg),
        .state      (state_reg),
        .write_addr (addr_reg),
        .write_data (data_reg),
        .state_next (state_next)
    );

    // Result register can load when empty or being drained this cycle
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    // Input register can load when empty or moving forward this cycle
    assign in_stall = in_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    assign out_valid       = out_valid_reg;
    assign rom_bank_now    = rom_bank_reg;
    assign ram_bank_now    = ram_bank_reg;
    assign ram_enabled_now = ram_en_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= BANK_STATE_RST;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            addr_reg <= write_addr;
            data_reg <= write_data;
        end
        if (advance)
        begin
            rom_bank_reg <= state_next.current_rom_bank;
            ram_bank_reg <= state_next.current_ram_bank;
            ram_en_reg   <= state_next.ram_enable_flag;
        end
    end

endmodule

// ===== hw/rtl/cbc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// cbc_cfg_regs
// Configuration registers: mapper kind and the two bank masks.
// ----------------------------------------------------------------------------
module cbc_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cbc_pkg::CFG_DATA_W-1:0] cfg_data,
    output cbc_pkg::cfg_t                  cfg
);
    import cbc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_MAPPER_KIND:   cfg_next.mapper_kind   = cfg_data[KIND_W-1:0];
                REG_ROM_BANK_MASK: cfg_next.rom_bank_mask = cfg_data[ROM_BANK_W-1:0];
                REG_RAM_BANK_MASK: cfg_next.ram_bank_mask = cfg_data[RAM_BANK_W-1:0];
                default:           cfg_next = cfg_reg;  // unmapped index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mapper_kind   <= MAPPER_KIND_RST;
            cfg_reg.rom_bank_mask <= ROM_BANK_MASK_RST;
            cfg_reg.ram_bank_mask <= RAM_BANK_MASK_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hw/rtl/cbc_bank_logic.sv =====
// ----------------------------------------------------------------------------
// cbc_bank_logic
// Next bank state for one CPU write, MBC1 and MBC5 decode.
// ----------------------------------------------------------------------------
module cbc_bank_logic (
    input  cbc_pkg::cfg_t                  cfg,
    input  cbc_pkg::bank_state_t           state,
    input  logic [cbc_pkg::ADDR_W-1:0]     write_addr,
    input  logic [cbc_pkg::DATA_W-1:0]     write_data,
    output cbc_pkg::bank_state_t           state_next
);
    import cbc_pkg::*;

    logic                  enable_region;
    logic                  ram_key_hit;
    bank_state_t           mbc1_fields;
    logic [6:0]            mbc1_bank;
    logic [6:0]            mbc1_bank_fixed;

    // 0x0000-0x1FFF is the RAM enable region for both mappers
    assign enable_region = (write_addr[14:13] == 2'b00);
    assign ram_key_hit   = (write_data[3:0] == RAM_ENABLE_KEY);

    // MBC1 field update, then bank recompute from the new fields
    always_comb
    begin
        mbc1_fields = state;
        case (write_addr[14:13])
            2'b01:   mbc1_fields.low_bank_field  = write_data[4:0];
            2'b10:   mbc1_fields.high_bank_field = write_data[1:0];
            2'b11:   mbc1_fields.mode_select     = write_data[0];
            default: mbc1_fields = state;
        endcase
    end

    assign mbc1_bank = mbc1_fields.mode_select
                     ? {2'b00, mbc1_fields.low_bank_field}
                     : {mbc1_fields.high_bank_field, mbc1_fields.low_bank_field};
    assign mbc1_bank_fixed = (mbc1_bank == 7'd0) ? 7'd1 : mbc1_bank;

    always_comb
    begin
        state_next = state;
        case (cfg.mapper_kind)
            KIND_MBC1:
            begin
                if (enable_region)
                begin
                    state_next.ram_enable_flag = ram_key_hit;
                end
                else
                begin
                    state_next = mbc1_fields;
                    state_next.current_rom_bank =
                        {2'b00, mbc1_bank_fixed} & cfg.rom_bank_mask;
                    state_next.current_ram_bank = mbc1_fields.mode_select
                        ? {2'b00, mbc1_fields.high_bank_field} : 4'd0;
                end
            end
            KIND_MBC5:
            begin
                if (enable_region)
                begin
                    state_next.ram_enable_flag = ram_key_hit;
                end
                else if (write_addr[14:12] == 3'b010)
                begin
                    state_next.current_rom_bank =
                        {state.current_rom_bank[8], write_data} & cfg.rom_bank_mask;
                end
                else if (write_addr[14:12] == 3'b011)
                begin
                    state_next.current_rom_bank =
                        {write_data[0], state.current_rom_bank[7:0]} & cfg.rom_bank_mask;
                end
                else if (write_addr[14:13] == 2'b10)
                begin
                    state_next.current_ram_bank = write_data[3:0] & cfg.ram_bank_mask;
                end
            end
            default: state_next = state;  // plain ROM and unsupported kinds
        endcase
    end

endmodule
